/* src/rpcd_pkg.sv */
// ----------------------------------------------------------------------------
// rpcd_pkg
// Shared types and constants for the cartridge patcher: transaction
// payloads, operation and source codes, mode register bit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpcd_pkg;

    localparam int DATA_W      = 16;
    localparam int ADDR_W      = 22;
    localparam int REG_IDX_W   = 5;   // register index taken from address[5:1]
    localparam int PATCH_HI_W  = 6;   // patch address high part, 0x3f mask

    localparam int PATCH_COUNT_DEF    = 6;
    localparam int REGISTER_COUNT_DEF = 32;

    // operation codes (code three behaves as a read)
    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_BYTE_WR  = 2'd1;
    localparam logic [1:0] OP_WORD_WR  = 2'd2;

    // read source codes
    localparam logic [1:0] SRC_CART    = 2'd0;
    localparam logic [1:0] SRC_ROM     = 2'd1;
    localparam logic [1:0] SRC_REGS    = 2'd2;
    localparam logic [1:0] SRC_WRITE   = 2'd3;

    // mode register (register 0) bit positions
    localparam int MODE_CART_BIT = 10;
    localparam int MODE_REGS_BIT = 9;
    localparam int MODE_LOCK_BIT = 8;

    // indexes of fixed registers
    localparam logic [REG_IDX_W-1:0] REG_MODE = 5'd0;
    localparam logic [REG_IDX_W-1:0] REG_ONE  = 5'd1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] cart_data;
        logic [DATA_W-1:0] genie_rom_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        read_source;
        logic              patched;
        logic              locked;
    } t_out_item;

endpackage

`default_nettype wire

/* src/rpcd_patch_match.sv */
// ----------------------------------------------------------------------------
// rpcd_patch_match
// Decodes the patch slots from the register file, matches a read word
// address against the enabled slots (lowest wins) and flags duplicate
// slot addresses for the lock operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpcd_patch_match
    import rpcd_pkg::*;
#(
    parameter int PATCH_COUNT    = PATCH_COUNT_DEF,
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic [REGISTER_COUNT-1:0][DATA_W-1:0] i_regs,
    input  wire logic [PATCH_COUNT-1:0]                i_enable,
    input  wire logic [ADDR_W-2:0]                     i_word_addr,
    output logic                                       o_hit,
    output logic [DATA_W-1:0]                          o_data,
    output logic [PATCH_COUNT-1:0]                     o_dup_mask
);

    logic [PATCH_COUNT-1:0][ADDR_W-1:0] w_paddr;
    logic [PATCH_COUNT-1:0][DATA_W-1:0] w_pdata;
    logic [PATCH_COUNT-1:0]             w_match;

    // slot fields; registers beyond the file read as zero
    for (genvar i = 0; i < PATCH_COUNT; i++) begin : g_slot
        localparam int IDX_HI = 2 + 3 * i;
        localparam int IDX_LO = 3 + 3 * i;
        localparam int IDX_DT = 4 + 3 * i;
        logic [PATCH_HI_W-1:0] w_hi;
        logic [DATA_W-1:0]     w_lo;

        if (IDX_HI < REGISTER_COUNT) begin : g_hi
            assign w_hi = i_regs[IDX_HI][PATCH_HI_W-1:0];
        end else begin : g_hi0
            assign w_hi = '0;
        end
        if (IDX_LO < REGISTER_COUNT) begin : g_lo
            assign w_lo = i_regs[IDX_LO];
        end else begin : g_lo0
            assign w_lo = '0;
        end
        if (IDX_DT < REGISTER_COUNT) begin : g_dt
            assign w_pdata[i] = i_regs[IDX_DT];
        end else begin : g_dt0
            assign w_pdata[i] = '0;
        end

        assign w_paddr[i] = {w_hi, w_lo};
        assign w_match[i] = i_enable[i] && (w_paddr[i][ADDR_W-1:1] == i_word_addr);

        // a slot is a duplicate if any earlier slot has the same address
        always_comb begin
            o_dup_mask[i] = 1'b0;
            for (int j = 0; j < i; j++) begin
                if (w_paddr[i] == w_paddr[j]) begin
                    o_dup_mask[i] = 1'b1;
                end
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        o_hit  = 1'b0;
        o_data = '0;
        for (int i = PATCH_COUNT - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_hit  = 1'b1;
                o_data = w_pdata[i];
            end
        end
    end

endmodule

`default_nettype wire

/* src/rom_patch_cheat_device_core.sv */
// ----------------------------------------------------------------------------
// rom_patch_cheat_device_core
// Pass-through cartridge patcher. Each input transaction is one bus access
// (read, byte write or word write); each produces exactly one result
// transaction. Before lock, writes below 0x10000 go to a bank of 16-bit
// registers; register 0 is the mode register. Bank-0 reads are served by
// the cartridge (mode bit 10), the registers (bit 9) or the device ROM.
// Setting mode bit 8 locks the device and arms the patch slots, with any
// slot whose address repeats an earlier one disabled. Once locked,
// cartridge reads whose word address matches an enabled slot return the
// slot data. Throughput is one transaction per clock while results are not
// stalled; each transaction passes the input register, then the result
// register, with the register file updated in the single pass between them
// so back-to-back accesses see each other's effects. Results stall under
// backpressure without losing the input side: the input register keeps taking
// transactions whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rom_patch_cheat_device_core
    import rpcd_pkg::*;
#(
    parameter int PATCH_COUNT    = PATCH_COUNT_DEF,
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    // ---- pipeline registers ------------------------------------------------
    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    // ---- device state ------------------------------------------------------
    logic [REGISTER_COUNT-1:0][DATA_W-1:0] r_regs;
    logic                                  r_lock;

    logic w_fire;      // input register moves into the result register
    logic w_in_acc;

    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ---- decode of the held access ------------------------------------------
    logic [REG_IDX_W-1:0] w_off;
    logic                 w_off_ok;
    logic                 w_bank0;
    logic                 w_is_write;
    logic [DATA_W-1:0]    w_mode;
    logic [DATA_W-1:0]    w_reg_rd;

    assign w_off    = r_in_item.address[REG_IDX_W:1];
    assign w_off_ok = ({1'b0, w_off} < (REG_IDX_W + 1)'(REGISTER_COUNT));
    assign w_bank0  = (r_in_item.address[ADDR_W-1:DATA_W] == '0);
    assign w_mode   = r_regs[REG_MODE];
    assign w_reg_rd = w_off_ok ? r_regs[w_off] : '0;

    always_comb begin
        unique case (r_in_item.operation)
            OP_BYTE_WR, OP_WORD_WR: w_is_write = 1'b1;
            default:                w_is_write = 1'b0;   // read, code three too
        endcase
    end

    // ---- patch slots -------------------------------------------------------
    logic                   w_hit;
    logic [DATA_W-1:0]      w_patch_data;
    logic [PATCH_COUNT-1:0] w_dup_mask;

    rpcd_patch_match #(
        .PATCH_COUNT    (PATCH_COUNT),
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_match (
        .i_regs      (r_regs),
        .i_enable    (w_mode[PATCH_COUNT-1:0]),
        .i_word_addr (r_in_item.address[ADDR_W-1:1]),
        .o_hit       (w_hit),
        .o_data      (w_patch_data),
        .o_dup_mask  (w_dup_mask)
    );

    // ---- register write path -----------------------------------------------
    // byte lane: even address writes the upper byte, odd the lower
    logic              w_wr_en;
    logic [DATA_W-1:0] w_wr_val;
    logic [DATA_W-1:0] n_reg_val;
    logic              n_lock;

    assign w_wr_en = w_is_write && !r_lock && w_bank0 && w_off_ok;

    always_comb begin
        if (r_in_item.operation == OP_WORD_WR) begin
            w_wr_val = r_in_item.write_data;
        end else if (r_in_item.address[0]) begin
            w_wr_val = {w_reg_rd[15:8], r_in_item.write_data[7:0]};
        end else begin
            w_wr_val = {r_in_item.write_data[7:0], w_reg_rd[7:0]};
        end

        n_reg_val = w_wr_val;
        n_lock    = r_lock;
        if (w_off == REG_MODE) begin
            if (w_wr_val[MODE_LOCK_BIT]) begin
                // lock: drop duplicate slots, mode bits stay as written
                n_reg_val = w_wr_val & ~DATA_W'(w_dup_mask);
                n_lock    = w_wr_en;
            end
        end else if (w_off == REG_ONE) begin
            n_reg_val = w_wr_val | DATA_W'(1);
        end
        if (!w_wr_en) begin
            n_lock = r_lock;
        end
    end

    // ---- result ------------------------------------------------------------
    t_out_item n_out_item;

    always_comb begin
        n_out_item.read_data   = '0;
        n_out_item.read_source = SRC_WRITE;
        n_out_item.patched     = 1'b0;
        n_out_item.locked      = n_lock;
        if (!w_is_write) begin
            if (w_bank0 && !w_mode[MODE_CART_BIT]) begin
                if (w_mode[MODE_REGS_BIT]) begin
                    n_out_item.read_data   = w_reg_rd;
                    n_out_item.read_source = SRC_REGS;
                end else begin
                    n_out_item.read_data   = r_in_item.genie_rom_data;
                    n_out_item.read_source = SRC_ROM;
                end
            end else begin
                n_out_item.read_source = SRC_CART;
                if (r_lock && w_hit) begin
                    n_out_item.read_data = w_patch_data;
                    n_out_item.patched   = 1'b1;
                end else begin
                    n_out_item.read_data = r_in_item.cart_data;
                end
            end
        end
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_lock    <= 1'b0;
            r_regs    <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end

            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (w_fire) begin
                r_lock <= n_lock;
                if (w_wr_en) begin
                    r_regs[w_off] <= n_reg_val;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* src/rpcd_checker.sv */
// ----------------------------------------------------------------------------
// rpcd_checker
// Port-level checks for the cartridge patcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpcd_checker
    import rpcd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_item
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pending;     // transactions taken but not yet delivered
    logic       r_seen_lock;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_seen_lock <= 1'b0;
        end else begin
            r_pending <= r_pending + 2'(w_in_acc) - 2'(w_out_acc);
            if (w_out_acc && i_out_item.locked) begin
                r_seen_lock <= 1'b1;
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // no result without a transaction taken for it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result with no pending transaction");

    // at most the input and result registers are occupied
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 |-> !i_in_ready || w_out_acc)
        else $error("transaction taken with both stages full");

    // lock is sticky across results
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_lock |-> i_out_item.locked)
        else $error("device unlocked after lock");

    // only locked cartridge reads are patched
    a_patch_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.patched |->
            i_out_item.read_source == SRC_CART && i_out_item.locked)
        else $error("patch outside a locked cartridge read");

endmodule

bind rom_patch_cheat_device_core rpcd_checker u_rpcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire
